// ----- hw/rtl/tccw_pkg.sv -----
// ============================================================================
// tccw_pkg: shared types and constants of the text console character writer
// Field widths, control character codes, operation and register codes, and
// the status record that travels with each word through the result stage.
// ============================================================================
package tccw_pkg;

    localparam int CHAR_W       = 8;
    localparam int ATTR_W       = 8;
    localparam int CELL_W       = CHAR_W + ATTR_W;
    localparam int CELL_INDEX_W = 11;
    localparam int POS_W        = 11;

    localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Register index on the configuration port (byte address bit 2).
    localparam logic REG_TEXT_ATTR = 1'b0;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    // Status of one accepted word, carried alongside the memory read.
    typedef struct packed {
        logic [POS_W-1:0] cursor_position;
        logic             scrolled;
        logic             rd_hit;
    } item_meta_t;

endpackage

// ----- hw/rtl/tccw_apb_regs.sv -----
// ============================================================================
// tccw_apb_regs: configuration register file
// Holds the text attribute register behind a simple APB-style slave port.
// ============================================================================
module tccw_apb_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [tccw_pkg::ATTR_W-1:0]     text_attr
);

    logic [tccw_pkg::ATTR_W-1:0] text_attr_reg;
    logic [tccw_pkg::ATTR_W-1:0] text_attr_next;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        text_attr_next = text_attr_reg;
        if (wr_en && (paddr[2] == tccw_pkg::REG_TEXT_ATTR)) begin
            text_attr_next = pwdata[tccw_pkg::ATTR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_attr_reg <= tccw_pkg::RESET_ATTR;
        end else begin
            text_attr_reg <= text_attr_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == tccw_pkg::REG_TEXT_ATTR) begin
            prdata = {{(32 - tccw_pkg::ATTR_W){1'b0}}, text_attr_reg};
        end
    end

    assign text_attr = text_attr_reg;

endmodule

// ----- hw/rtl/tccw_screen_ram.sv -----
// ============================================================================
// tccw_screen_ram: screen cell memory
// One write port and one read port, registered read data.
// ============================================================================
module tccw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [tccw_pkg::CELL_W-1:0]   wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [tccw_pkg::CELL_W-1:0]   rdata
);

    logic [tccw_pkg::CELL_W-1:0] cell_mem [DEPTH];
    logic [tccw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            cell_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= cell_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tccw_cursor_ctrl.sv -----
// ============================================================================
// tccw_cursor_ctrl: cursor, scroll offset and memory sequencing
// Tracks the cursor and the circular top row, forms the physical addresses
// of writes and reads, and runs the clearing sweeps after reset and scroll.
// ============================================================================
module tccw_cursor_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_accept,
    input  tccw_pkg::op_t                         op,
    input  logic [tccw_pkg::CHAR_W-1:0]           char_code,
    input  logic [tccw_pkg::CELL_INDEX_W-1:0]     cell_index,
    input  logic [tccw_pkg::ATTR_W-1:0]           text_attr,
    output logic                                  busy,
    output tccw_pkg::item_meta_t                  meta,
    output logic                                  mem_we,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_waddr,
    output logic [tccw_pkg::CELL_W-1:0]           mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(COLUMNS*ROWS)-1:0]       mem_raddr
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int IDX_W      = ((tccw_pkg::CELL_INDEX_W > ADDR_W) ?
                                 tccw_pkg::CELL_INDEX_W : ADDR_W) + 1;
    localparam int SUM_W      = (tccw_pkg::POS_W > ADDR_W) ? tccw_pkg::POS_W : ADDR_W;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(CELL_COUNT - COLUMNS);

    // Cursor column and row, linear base of the cursor row, physical base of
    // the cursor row and of the top screen row (all row bases are row*COLUMNS).
    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ADDR_W-1:0] lin_reg,  lin_next;
    logic [ADDR_W-1:0] cur_reg,  cur_next;
    logic [ADDR_W-1:0] top_reg,  top_next;
    logic [CNT_W-1:0]  clr_cnt_reg,  clr_cnt_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [tccw_pkg::ATTR_W-1:0] clr_attr_reg, clr_attr_next;

    logic              put_item;
    logic              put_char;
    logic              advance;
    logic              scroll;
    logic [ADDR_W-1:0] cur_adv;
    logic [ADDR_W-1:0] top_adv;
    logic [SUM_W-1:0]  pos_sum;
    logic              in_range;
    logic [IDX_W-1:0]  idx_sum;
    logic [IDX_W-1:0]  idx_phys;

    assign busy     = (clr_cnt_reg != '0);
    assign put_item = in_accept && (op == tccw_pkg::OP_PUT);
    assign cur_adv  = (cur_reg == LAST_BASE) ? '0 : cur_reg + ROW_STEP;
    assign top_adv  = (top_reg == LAST_BASE) ? '0 : top_reg + ROW_STEP;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        lin_next = lin_reg;
        cur_next = cur_reg;
        top_next = top_reg;
        put_char = 1'b0;
        advance  = 1'b0;
        scroll   = 1'b0;
        if (put_item) begin
            unique case (char_code)
                tccw_pkg::CH_CR: begin
                    col_next = '0;
                end
                tccw_pkg::CH_LF: begin
                    advance = 1'b1;
                end
                default: begin
                    put_char = 1'b1;
                    if (col_reg == COL_LAST) begin
                        advance = 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            endcase
        end
        if (advance) begin
            col_next = '0;
            cur_next = cur_adv;
            if (row_reg == ROW_LAST) begin
                // The old top row becomes the new bottom line.
                scroll   = 1'b1;
                top_next = top_adv;
            end else begin
                row_next = row_reg + 1'b1;
                lin_next = lin_reg + ROW_STEP;
            end
        end
    end

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_addr_next = clr_addr_reg;
        clr_attr_next = clr_attr_reg;
        if (scroll) begin
            clr_cnt_next  = CNT_W'(COLUMNS);
            clr_addr_next = top_reg;
            clr_attr_next = text_attr;
        end else if (busy) begin
            clr_cnt_next  = clr_cnt_reg - 1'b1;
            clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            lin_reg      <= '0;
            cur_reg      <= '0;
            top_reg      <= '0;
            clr_cnt_reg  <= CNT_W'(CELL_COUNT);
            clr_addr_reg <= '0;
            clr_attr_reg <= tccw_pkg::RESET_ATTR;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            lin_reg      <= lin_next;
            cur_reg      <= cur_next;
            top_reg      <= top_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_addr_reg <= clr_addr_next;
            clr_attr_reg <= clr_attr_next;
        end
    end

    // Write port: the clearing sweep owns it while busy; input is held off then.
    assign mem_we    = busy | put_char;
    assign mem_waddr = busy ? clr_addr_reg : (cur_reg + ADDR_W'(col_reg));
    assign mem_wdata = busy ? {clr_attr_reg, {tccw_pkg::CHAR_W{1'b0}}}
                            : {text_attr, char_code};

    // The physical cell of a screen-order index is (index + top base) modulo
    // the cell count; both terms are in range for a read that is taken, so one subtraction suffices.
    assign in_range  = (IDX_W'(cell_index) < IDX_W'(CELL_COUNT));
    assign idx_sum   = IDX_W'(cell_index) + IDX_W'(top_reg);
    assign idx_phys  = (idx_sum >= IDX_W'(CELL_COUNT)) ? idx_sum - IDX_W'(CELL_COUNT)
                                                       : idx_sum;
    assign mem_re    = in_accept && (op == tccw_pkg::OP_READ) && in_range;
    assign mem_raddr = idx_phys[ADDR_W-1:0];

    assign pos_sum              = SUM_W'(lin_next) + SUM_W'(col_next);
    assign meta.cursor_position = pos_sum[tccw_pkg::POS_W-1:0];
    assign meta.scrolled        = scroll;
    assign meta.rd_hit          = mem_re;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |-> !busy)
        else $error("word accepted during a clearing sweep");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("cursor outside the screen");

    a_base_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg <= LAST_BASE) && (top_reg <= LAST_BASE) && (lin_reg <= LAST_BASE))
        else $error("row base outside the screen store");

    a_scroll_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && scroll) |=>
            ((clr_cnt_reg == CNT_W'(COLUMNS)) && (clr_addr_reg == $past(top_reg))))
        else $error("scroll did not start a sweep of the old top row");

endmodule

// ----- hw/rtl/text_console_char_writer_top.sv -----
// ============================================================================
// text_console_char_writer_top: character-cell text console
// Puts characters at a cursor with carriage return, line feed, wrap and
// scroll, and reads screen cells in screen order for scan-out.
// ============================================================================
//
//  Channel   Dir  Handshake          Contents
//  s_        in   tvalid/tready      tuser: operation; tdata: char, cell index
//  m_        out  tvalid/tready      tdata: cursor, scrolled, cell char/attr
//  APB       in   psel/penable       register 0: text attribute
//
//  One word per cycle while s_tready is high; each result passes through the read
//  stage and the output register. After reset a sweep blanks every cell of the
//  screen store, with s_tready low; configuration writes are taken during it.
//  A put that scrolls holds s_tready low while the one write port clears the
//  new bottom line.
//  A stalled m_ side fills the output register and the read stage, then
//  stops input.
//
module text_console_char_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [0:0]  s_tuser,   // [0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [10:0] cursor_position, [11] scrolled,
                                   // [19:12] cell_char, [27:20] cell_attr, rest zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [tccw_pkg::ATTR_W-1:0] text_attr;
    logic                        busy;
    logic                        in_accept;
    tccw_pkg::item_meta_t        meta;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tccw_pkg::CELL_W-1:0] mem_rdata;

    logic                        s1_valid_reg, s1_valid_next;
    tccw_pkg::item_meta_t        s1_meta_reg;
    logic                        s1_move;
    logic                        out_valid_reg, out_valid_next;
    logic [tccw_pkg::POS_W-1:0]  out_pos_reg;
    logic                        out_scrolled_reg;
    logic [tccw_pkg::CHAR_W-1:0] out_char_reg;
    logic [tccw_pkg::ATTR_W-1:0] out_attr_reg;

    tccw_apb_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .text_attr (text_attr)
    );

    tccw_cursor_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .op         (tccw_pkg::op_t'(s_tuser[0])),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .text_attr  (text_attr),
        .busy       (busy),
        .meta       (meta),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    tccw_screen_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The read data of the memory lines up with the first stage; the
    // memory output holds while that stage waits, since nothing new is read.
    assign s1_move   = s1_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready  = ~busy & (~s1_valid_reg | s1_move);
    assign in_accept = s_tvalid & s_tready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_meta_reg <= meta;
        end
        if (s1_move) begin
            out_pos_reg      <= s1_meta_reg.cursor_position;
            out_scrolled_reg <= s1_meta_reg.scrolled;
            out_char_reg     <= s1_meta_reg.rd_hit ? mem_rdata[tccw_pkg::CHAR_W-1:0] : '0;
            out_attr_reg     <= s1_meta_reg.rd_hit ?
                                mem_rdata[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W] : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_attr_reg, out_char_reg, out_scrolled_reg, out_pos_reg};

endmodule

// ----- tb/text_console_char_writer_top_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// text_console_char_writer_top_tb: self-checking bench for the text console
// Drives put and read words on the input stream and compares each result
// word against a behavioral console model kept in the bench. The text
// attribute register is changed between phases over the APB port, and both
// stream sides are throttled at random, including one long output hold-off.
// ============================================================================
module text_console_char_writer_top_tb;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int HOLD_OFF   = 64;
    localparam logic [2:0] TEXT_ATTR_ADDR = {tccw_pkg::REG_TEXT_ATTR, 2'b00};

    typedef struct packed {
        logic [tccw_pkg::POS_W-1:0]  cursor_position;
        logic                        scrolled;
        logic [tccw_pkg::CHAR_W-1:0] cell_char;
        logic [tccw_pkg::ATTR_W-1:0] cell_attr;
    } console_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Console state as the block should hold it.
    logic [tccw_pkg::CELL_W-1:0] screen_mem [0:CELL_COUNT-1];
    int unsigned                 cur_col;
    int unsigned                 cur_row;
    int unsigned                 top_row;
    logic [tccw_pkg::ATTR_W-1:0] attr_shadow;

    console_result_t pending_results [$];

    int  error_count = 0;
    int  put_count   = 0;
    int  read_count  = 0;
    int  scroll_count = 0;
    int  attr_writes = 0;
    int  idle_pct    = 0;
    int  stall_pct   = 0;
    bit  hold_request = 1'b0;
    int  hold_left   = 0;

    text_console_char_writer_top #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    // Returns the cursor to column 0 of the next row, scrolling at the bottom.
    function automatic bit line_advance();
        int unsigned base;
        cur_col = 0;
        if (cur_row + 1 < ROWS) begin
            cur_row++;
            return 1'b0;
        end
        // The old top physical row becomes the new, blanked bottom line.
        base = top_row * COLUMNS;
        for (int c = 0; c < COLUMNS; c++) begin
            screen_mem[base + c] = {attr_shadow, 8'h00};
        end
        top_row = (top_row + 1) % ROWS;
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic console_result_t console_apply(
        tccw_pkg::op_t                     op,
        logic [tccw_pkg::CHAR_W-1:0]       ch,
        logic [tccw_pkg::CELL_INDEX_W-1:0] idx
    );
        console_result_t             res;
        int unsigned                 addr;
        int unsigned                 lin;
        logic [tccw_pkg::CELL_W-1:0] cell_word;
        res = '0;
        lin = idx;
        if (op == tccw_pkg::OP_PUT) begin
            if (ch == tccw_pkg::CH_CR) begin
                cur_col = 0;
            end else if (ch == tccw_pkg::CH_LF) begin
                res.scrolled = line_advance();
            end else begin
                addr = ((cur_row + top_row) % ROWS) * COLUMNS + cur_col;
                screen_mem[addr] = {attr_shadow, ch};
                cur_col++;
                if (cur_col >= COLUMNS) begin
                    res.scrolled = line_advance();
                end
            end
        end else if (lin < CELL_COUNT) begin
            cell_word = screen_mem[((lin / COLUMNS + top_row) % ROWS) * COLUMNS
                                   + lin % COLUMNS];
            res.cell_char = cell_word[7:0];
            res.cell_attr = cell_word[15:8];
        end
        res.cursor_position = tccw_pkg::POS_W'((cur_row * COLUMNS + cur_col) & 'h7FF);
        return res;
    endfunction

    // Offers one word and records its expected result once it is accepted.
    task automatic send_word(tccw_pkg::op_t op, logic [tccw_pkg::CHAR_W-1:0] ch,
                             logic [tccw_pkg::CELL_INDEX_W-1:0] idx);
        console_result_t res;
        @(negedge aclk);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, idx, ch};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        res = console_apply(op, ch, idx);
        pending_results.push_back(res);
        if (op == tccw_pkg::OP_PUT) put_count++;
        else read_count++;
        if (res.scrolled) scroll_count++;
    endtask

    task automatic send_random_word();
        int unsigned r;
        int unsigned k;
        logic [tccw_pkg::CHAR_W-1:0]       ch;
        logic [tccw_pkg::CELL_INDEX_W-1:0] idx;
        r   = $urandom_range(99);
        ch  = tccw_pkg::CHAR_W'($urandom);
        idx = tccw_pkg::CELL_INDEX_W'($urandom);
        if (r < 20) begin
            k = $urandom_range(99);
            if (k < 10) begin
                idx = tccw_pkg::CELL_INDEX_W'(cur_row * COLUMNS
                                              + $urandom_range(COLUMNS - 1));
            end else if (k < 15) begin
                idx = tccw_pkg::CELL_INDEX_W'($urandom_range(2047, CELL_COUNT));
            end else begin
                idx = tccw_pkg::CELL_INDEX_W'($urandom_range(CELL_COUNT - 1));
            end
            send_word(tccw_pkg::OP_READ, ch, idx);
        end else begin
            k = $urandom_range(99);
            if (k < 8) ch = tccw_pkg::CH_LF;
            else if (k < 12) ch = tccw_pkg::CH_CR;
            send_word(tccw_pkg::OP_PUT, ch, idx);
        end
    endtask

    // Lets the block run dry, including the tail of a bottom-line clear.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (COLUMNS + 8) @(negedge aclk);
    endtask

    task automatic write_text_attr(logic [tccw_pkg::ATTR_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_ATTR_ADDR;
        pwdata  <= {24'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        attr_shadow = value;
        attr_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(int send_idle, int recv_stall);
        @(posedge aclk);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
    endtask

    task automatic test_directed_cases();
        set_idling(0, 0);
        // Reset contents, the last cell, and reads past the end of the screen.
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'hFF, 11'd1999);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd2000);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'h7FF);
        send_word(tccw_pkg::OP_PUT, 8'h00, 11'h7FF);
        send_word(tccw_pkg::OP_PUT, 8'hFF, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'h41, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'h01, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'h7F, 11'd0);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, 11'd0);
        // After a carriage return the next character lands on column 0 again.
        send_word(tccw_pkg::OP_PUT, 8'h58, 11'd0);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 11'd0);
        send_word(tccw_pkg::OP_PUT, 8'h59, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd1);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd3);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd4);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd5);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd80);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd81);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_LF, 11'd0);
        send_word(tccw_pkg::OP_PUT, tccw_pkg::CH_CR, 11'd0);
        send_word(tccw_pkg::OP_READ, 8'h00, 11'd160);
    endtask

    task automatic test_random_traffic(int count, logic [tccw_pkg::ATTR_W-1:0] attr_value,
                                       int send_idle, int recv_stall);
        write_text_attr(attr_value);
        set_idling(send_idle, recv_stall);
        repeat (count) send_random_word();
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        set_idling(0, 0);
        @(posedge aclk);
        hold_request = 1'b1;
        repeat (40) send_random_word();
    endtask

    // Result side ready, with random stalls and one long requested hold-off.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[10:0] !== want.cursor_position) begin
                    $error("cursor_position: expected %0d, got %0d",
                           want.cursor_position, m_tdata[10:0]);
                    error_count++;
                end
                if (m_tdata[11] !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, m_tdata[11]);
                    error_count++;
                end
                if (m_tdata[19:12] !== want.cell_char) begin
                    $error("cell_char: expected %h, got %h", want.cell_char, m_tdata[19:12]);
                    error_count++;
                end
                if (m_tdata[27:20] !== want.cell_attr) begin
                    $error("cell_attr: expected %h, got %h", want.cell_attr, m_tdata[27:20]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            screen_mem[i] = {tccw_pkg::RESET_ATTR, 8'h00};
        end
        cur_col     = 0;
        cur_row     = 0;
        top_row     = 0;
        attr_shadow = tccw_pkg::RESET_ATTR;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_random_traffic(345, 8'h00, 0, 0);
        test_random_traffic(345, 8'hFF, 69, 0);
        test_output_backpressure();
        test_random_traffic(345, tccw_pkg::ATTR_W'($urandom), 0, 69);
        test_random_traffic(345, tccw_pkg::RESET_ATTR, 36, 36);

        wait_drained();
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        $display("Run covered %0d puts and %0d reads, %0d of them scrolling the screen.",
                 put_count, read_count, scroll_count);
        $display("Text attribute was rewritten %0d times across the idling phases.",
                 attr_writes);
        if (error_count == 0) begin
            $display("text_console_char_writer_top_tb: clean");
        end else begin
            $display("text_console_char_writer_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Timeout: stimulus or results stopped moving.");
        $display("text_console_char_writer_top_tb: errors");
        $finish;
    end

endmodule

// ----- text_console_char_writer_top.f -----
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_apb_regs.sv
hw/rtl/tccw_screen_ram.sv
hw/rtl/tccw_cursor_ctrl.sv
hw/rtl/text_console_char_writer_top.sv
tb/text_console_char_writer_top_tb.sv
